@@ sv/first_fit_block_allocator_defines.svh @@
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define FFBA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ffba_pkg.sv @@
`default_nettype none

package ffba_pkg;

    localparam int ADDR_W           = 22;
    localparam int MAX_BLOCKS_DEF   = 256;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int PAD_BYTES_DEF    = 4;
    localparam int CFG_IDX_W        = 1;

    localparam logic [ADDR_W-1:0] HEAP_START_RST = 22'd0;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 22'd4063232;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        OUTC_DONE     = 2'd0,
        OUTC_ZERO     = 2'd1,
        OUTC_NOMEM    = 2'd2,
        OUTC_NOTFOUND = 2'd3
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_START = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t   op;
        addr_t request_size;
        addr_t payload_address;
    } in_item_t;

    typedef struct packed {
        addr_t    granted_address;
        outcome_t outcome;
        addr_t    bytes_used;
    } out_item_t;

    typedef struct packed {
        addr_t origin;
        addr_t length;
        logic  busy;
    } entry_t;

    typedef struct packed {
        addr_t heap_start;
        addr_t heap_limit;
    } cfg_t;

endpackage

`default_nettype wire

@@ sv/ffba_table.sv @@
`default_nettype none

module ffba_table #(
    parameter int DEPTH = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output ffba_pkg::entry_t      rd_data,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  ffba_pkg::entry_t      wr_data
);
    import ffba_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/ffba_ctrl.sv @@
`default_nettype none
`include "first_fit_block_allocator_defines.svh"

module ffba_ctrl #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int PAD_BYTES    = ffba_pkg::PAD_BYTES_DEF,
    parameter int IDX_W        = $clog2(MAX_BLOCKS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffba_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ffba_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ffba_pkg::out_item_t   out_item,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    input  ffba_pkg::entry_t      rd_data,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output ffba_pkg::entry_t      wr_data
);
    import ffba_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0]  MaxCnt  = CNT_W'(MAX_BLOCKS);
    localparam logic [ADDR_W-1:0] HdrW    = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] ExtraW  = ADDR_W'(HEADER_BYTES + PAD_BYTES);
    localparam logic [ADDR_W-1:0] AddrMax = {ADDR_W{1'b1}};

    state_t            state_reg, state_next;
    in_item_t          req_reg, req_next;
    out_item_t         res_reg, res_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    addr_t             append_reg, append_next;
    addr_t             used_reg, used_next;

    logic              is_alloc;
    logic              hit;
    logic [ADDR_W:0]   free_key;
    addr_t             used_add_hit;
    addr_t             used_sub_hit;
    logic [ADDR_W:0]   hdr;
    logic [ADDR_W+1:0] hdr_end;
    logic [ADDR_W+1:0] append_sum;
    addr_t             used_add_new;
    logic              no_room;

    function automatic addr_t sat_add(input addr_t base, input addr_t len);
        logic [ADDR_W+1:0] s;
        s = {2'b00, base} + {2'b00, len} + {2'b00, ExtraW};
        return (s > {2'b00, AddrMax}) ? AddrMax : s[ADDR_W-1:0];
    endfunction

    function automatic addr_t floor_sub(input addr_t base, input addr_t len);
        logic [ADDR_W:0] d;
        d = {1'b0, len} + {1'b0, ExtraW};
        return ({1'b0, base} > d) ? addr_t'({1'b0, base} - d) : '0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            append_reg    <= '0;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            append_reg    <= append_next;
            used_reg      <= used_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
    end

    // datapath shared by the scan and append steps
    always_comb
    begin
        is_alloc     = (req_reg.op == OP_ALLOC);
        free_key     = {1'b0, rd_data.origin} + {1'b0, HdrW};
        used_add_hit = sat_add(used_reg, rd_data.length);
        used_sub_hit = floor_sub(used_reg, rd_data.length);
        if (is_alloc)
        begin
            hit = pend_reg && !rd_data.busy && (rd_data.length >= req_reg.request_size);
        end
        else
        begin
            hit = pend_reg && rd_data.busy && (free_key == {1'b0, req_reg.payload_address});
        end
        hdr          = {1'b0, cfg.heap_start} + {1'b0, append_reg};
        hdr_end      = {1'b0, hdr} + {2'b00, req_reg.request_size} + {2'b00, HdrW};
        append_sum   = {2'b00, append_reg} + {2'b00, req_reg.request_size}
                       + {2'b00, ExtraW};
        used_add_new = sat_add(used_reg, req_reg.request_size);
        no_room      = (total_reg >= MaxCnt) || (hdr_end >= {2'b00, cfg.heap_limit});
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        total_next     = total_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        append_next    = append_reg;
        used_next      = used_reg;
        in_ready       = (state_reg == ST_IDLE);
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = pend_idx_reg;
        wr_data        = rd_data;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = in_item;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    if (in_item.op == OP_ALLOC && in_item.request_size == '0)
                    begin
                        res_next   = '{granted_address: '0, outcome: OUTC_ZERO,
                                       bytes_used: used_reg};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    wr_en        = 1'b1;
                    wr_data.busy = is_alloc;
                    pend_next    = 1'b0;
                    state_next   = ST_DONE;
                    if (is_alloc)
                    begin
                        used_next = used_add_hit;
                        res_next  = '{granted_address: free_key[ADDR_W-1:0],
                                      outcome: OUTC_DONE, bytes_used: used_add_hit};
                    end
                    else
                    begin
                        used_next = used_sub_hit;
                        res_next  = '{granted_address: '0, outcome: OUTC_DONE,
                                      bytes_used: used_sub_hit};
                    end
                end
                else if (rd_idx_reg < total_reg)
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (is_alloc)
                    begin
                        state_next = ST_APPEND;
                    end
                    else
                    begin
                        res_next   = '{granted_address: '0, outcome: OUTC_NOTFOUND,
                                       bytes_used: used_reg};
                        state_next = ST_DONE;
                    end
                end
            end
            ST_APPEND:
            begin
                state_next = ST_DONE;
                if (no_room)
                begin
                    res_next = '{granted_address: '0, outcome: OUTC_NOMEM,
                                 bytes_used: used_reg};
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = total_reg[IDX_W-1:0];
                    wr_data     = '{origin: hdr[ADDR_W-1:0],
                                    length: req_reg.request_size, busy: 1'b1};
                    total_next  = total_reg + 1'b1;
                    append_next = (append_sum > {2'b00, AddrMax}) ? AddrMax
                                                                : append_sum[ADDR_W-1:0];
                    used_next   = used_add_new;
                    res_next    = '{granted_address: ADDR_W'(hdr + {1'b0, HdrW}),
                                    outcome: OUTC_DONE, bytes_used: used_add_new};
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    `FFBA_ASSERT_ALWAYS(a_total_bound, total_reg <= MaxCnt, "block count above table depth")
    `FFBA_ASSERT_ALWAYS(a_write_state, !wr_en || state_reg == ST_SCAN || state_reg == ST_APPEND,
        "table written outside scan or append")
    `FFBA_ASSERT_ALWAYS(a_scan_bound, state_reg != ST_SCAN || rd_idx_reg <= total_reg,
        "scan index past block count")
    `FFBA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_reg != ST_IDLE,
        "accepted item did not start")
    `FFBA_ASSERT_NEXT(a_total_step, state_reg != ST_APPEND,
        total_reg == $past(total_reg), "block count changed outside append")

endmodule

`default_nettype wire

@@ sv/first_fit_block_allocator.sv @@
// First-fit block allocator without splitting or merging.
// Input channel in_valid/in_ready carries one request item (allocate or free);
// output channel out_valid/out_ready returns exactly one result item per request.
// Configuration: cfg_write with cfg_index/cfg_data sets heap_start (0) or
// heap_limit (1); write only while no item is in flight.
// Flow: a zero-size allocate skips the walk and returns outcome zero.
// Otherwise the block table memory is walked one entry per cycle from entry 0;
// a hit ends the walk, and a full miss returns not found (free) or moves to
// the append step (allocate), which adds a block or reports out of memory.
// The single read port of the table sets the walk rate; one item is worked at
// a time, and a new item is accepted only once the last result is registered.
// Reset clears block count, append offset and used bytes and loads the
// register defaults; table contents are not cleared, no clearing pass.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and worked, and its result waits until the register frees.
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int PAD_BYTES    = ffba_pkg::PAD_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ffba_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ffba_pkg::out_item_t                 out_item
);
    import ffba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    cfg_t             cfg_reg, cfg_next;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{heap_start: HEAP_START_RST, heap_limit: HEAP_LIMIT_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HEAP_START: cfg_next.heap_start = cfg_data;
                CFG_HEAP_LIMIT: cfg_next.heap_limit = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    ffba_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .PAD_BYTES    (PAD_BYTES),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    ffba_table #(
        .DEPTH (MAX_BLOCKS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire
